// File: rtl/lifo_stack_search_assert.svh
// Assertion macros for the LIFO stack with search.
`ifndef LIFO_STACK_SEARCH_ASSERT_SVH
`define LIFO_STACK_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lifo_stack_search: assertion failed");
// Next-cycle implication, checked out of reset.
`define LSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lifo_stack_search: assertion failed");
`else
`define LSS_ASSERT_NOW(label, ante, cons)
`define LSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/lss_pkg.sv
// Package: word type, command and status codes for the LIFO stack with search.
`timescale 1ns / 1ps
package lss_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic [1:0]         cmd_t;

    localparam cmd_t CMD_PUSH   = 2'd0;
    localparam cmd_t CMD_POP    = 2'd1;
    localparam cmd_t CMD_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    localparam int COUNT_W = 5;

endpackage

// File: rtl/lifo_stack_search.sv
// LIFO stack with top-to-bottom search: top level.
`timescale 1ns / 1ps
`include "lifo_stack_search_assert.svh"
// lifo_stack_search
// A last-in first-out stack of DEPTH signed 32-bit words. A command word
// (cmd, value) is taken at a clock edge where start is high and busy is low.
// cmd 0 pushes value, 1 pops the top entry, 2 searches every held entry for
// value starting at the top; cmd 3 does nothing and reports the stack.
// Each command gives exactly one result word, shown on status, found,
// top_value, not_empty and entry_count for the single cycle in which done
// is high. The receiver cannot stall: sample the result when done is high.
// For push, failed pop, pop that empties the stack, cmd 3 and search on an
// empty stack, done is registered at the accepting edge. A pop that leaves
// entries passes through S_POP_WAIT while the new top is read back from
// the RAM. A search walks the held entries from the top in S_SEARCH until
// a hit or the bottom entry.
// The entry RAM has a single synchronous-read port, and a search walks it
// one entry per cycle. busy is high from the accepting
// edge until the edge that raises done, so a new command can be started in
// the cycle done is high. The current top is held in a register, so pushes
// never read the RAM. Pop on an empty stack reports status 1 and push on a
// full stack reports status 2; neither changes the stack. entry_count is the
// low 5 bits of the fill count. No clearing pass: the RAM is never read
// above the fill count.
module lifo_stack_search #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lss_pkg::cmd_t        cmd,
    input  lss_pkg::word_t       value,
    output logic                 done,
    output logic [1:0]           status,
    output logic                 found,
    output lss_pkg::word_t       top_value,
    output logic                 not_empty,
    output logic [lss_pkg::COUNT_W-1:0] entry_count
);
    import lss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SEARCH
    } state_t;

    // entry RAM, one write and one registered read per cycle
    word_t          mem [DEPTH];
    word_t          rdata_reg;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;

    state_t         state_reg,    state_next;
    logic [CW-1:0]  count_reg,    count_next;
    word_t          top_reg,      top_next;
    word_t          key_reg,      key_next;
    logic [AW-1:0]  scan_idx_reg, scan_idx_next;  // address held in rdata_reg
    logic           done_reg,     done_next;
    status_t        status_reg,   status_next;
    logic           found_reg,    found_next;

    logic [CW-1:0]  cnt_m1;
    logic [CW-1:0]  cnt_m2;
    logic           is_full;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign cnt_m1  = count_reg - CW'(1);
    assign cnt_m2  = count_reg - CW'(2);
    assign is_full = (count_reg == CW'(DEPTH));
    assign wr_addr = count_reg[AW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        key_next      = key_reg;
        scan_idx_next = scan_idx_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        found_next    = found_reg;
        wr_en         = 1'b0;
        rd_addr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    found_next  = 1'b0;
                    status_next = STAT_OK;
                    case (cmd)
                        CMD_PUSH:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                top_next   = value;
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                if (cnt_m1 == '0)
                                begin
                                    top_next  = '0;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    // fetch the entry that becomes the top
                                    rd_addr    = cnt_m2[AW-1:0];
                                    state_next = S_POP_WAIT;
                                end
                            end
                        end
                        CMD_SEARCH:
                        begin
                            key_next = value;
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr       = cnt_m1[AW-1:0];
                                scan_idx_next = cnt_m1[AW-1:0];
                                state_next    = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                top_next   = rdata_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SEARCH:
            begin
                if (rdata_reg == key_reg)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (scan_idx_reg == '0)
                begin
                    found_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr       = scan_idx_reg - AW'(1);
                    scan_idx_next = scan_idx_reg - AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM: no reset, entries above the fill count are never read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            top_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= STAT_OK;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        scan_idx_reg <= scan_idx_next;
    end

    assign cnt_ext     = (CW + COUNT_W)'(count_reg);
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign top_value   = top_reg;
    assign not_empty   = (count_reg != '0);
    assign entry_count = cnt_ext[COUNT_W-1:0];

    `LSS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `LSS_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE)
    `LSS_ASSERT_NOW(a_empty_top_zero, count_reg == '0, top_reg == '0)
    `LSS_ASSERT_NOW(a_scan_in_range, state_reg == S_SEARCH, CW'(scan_idx_reg) < count_reg)
    `LSS_ASSERT_NEXT(a_push_grows, start && !busy && cmd == CMD_PUSH && !is_full,
        count_reg == $past(count_reg) + CW'(1))

endmodule

// File: dv/lifo_stack_search_tb.sv
// Testbench for the LIFO stack with search: directed command table, then random commands.
`timescale 1ns / 1ps
// lifo_stack_search_tb
// Drives push, pop, search and the unused command into the stack. Commands
// go in at the falling edge and are taken at the rising edge where start is
// high and busy is low. Results are picked up at the rising edge while done
// is high; the receiver cannot stall the block, so only the sender idles.
// A shadow stack (array plus fill count) predicts results; typed directed rows carry
// their own. Each done word is checked field by field against the oldest expected word.
module lifo_stack_search_tb;
    import lss_pkg::*;

    localparam int DEPTH           = 16;
    localparam cmd_t CMD_NOP       = 2'd3;    // unused code, reports the stack only
    localparam int WORDS_PER_PHASE = 350;
    localparam int DRAIN_CYCLES    = DEPTH + 4; // longest search plus margin
    // Bound from the slowest run: ~1430 words, each with the longest idle gap and the longest search.
    localparam int CYCLE_LIMIT     = 400000;

    // One result word as the block reports it.
    typedef struct {
        status_t              status;
        logic                 found;
        word_t                top;
        logic                 not_empty;
        logic [COUNT_W-1:0]   count;
    } stack_view_t;

    // One row of the directed table; typed rows carry their own answer.
    typedef struct {
        cmd_t        op;
        word_t       arg;
        bit          typed;
        stack_view_t view;
    } cmd_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    cmd_t               cmd = CMD_PUSH;
    word_t              value = '0;
    logic               done;
    logic [1:0]         status;
    logic               found;
    word_t              top_value;
    logic               not_empty;
    logic [COUNT_W-1:0] entry_count;

    // Shadow stack: entries below shadow_fill are live, the rest are stale.
    word_t       shadow_mem [DEPTH];
    int          shadow_fill;
    word_t       last_pushed;

    stack_view_t pending_views [$];
    cmd_row_t    directed_rows [$];

    int errors;
    int cycle_count;
    int words_sent;
    int results_seen;
    int full_refusals;
    int empty_pops;
    int searches;
    int search_hits;

    lifo_stack_search #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .value       (value),
        .done        (done),
        .status      (status),
        .found       (found),
        .top_value   (top_value),
        .not_empty   (not_empty),
        .entry_count (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one command to the shadow stack and return the word it reports.
    // A failed push or pop leaves the stack alone; search looks only at
    // live entries, so stale values above the fill count never match.
    function automatic stack_view_t apply_command(input cmd_t op, input word_t arg);
        stack_view_t v;
        v.status = STAT_OK;
        v.found  = 1'b0;
        case (op)
            CMD_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                    v.status = STAT_FULL;
                else
                begin
                    shadow_mem[shadow_fill] = arg;
                    shadow_fill++;
                end
            end
            CMD_POP:
            begin
                if (shadow_fill == 0)
                    v.status = STAT_EMPTY;
                else
                    shadow_fill--;
            end
            CMD_SEARCH:
            begin
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_mem[i] == arg)
                        v.found = 1'b1;
            end
            default:
                ;
        endcase
        v.top       = (shadow_fill > 0) ? shadow_mem[shadow_fill - 1] : '0;
        v.not_empty = (shadow_fill > 0);
        v.count     = COUNT_W'(shadow_fill);
        return v;
    endfunction

    // Word values: often random, some small (so repeats and search hits
    // happen), some extremes, some taken back from the store.
    function automatic word_t pick_word();
        word_t w;
        case ($urandom_range(9))
            0, 1, 2, 3: w = $urandom;
            4, 5:       w = $signed($urandom_range(8)) - 4;
            6:          w = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            7:          w = last_pushed;
            default:    w = shadow_mem[$urandom_range(DEPTH - 1)];
        endcase
        return w;
    endfunction

    task automatic add_row(input cmd_t op, input word_t arg, input bit typed,
                           input status_t st, input logic fnd, input word_t top,
                           input int cnt);
        cmd_row_t r;
        r.op             = op;
        r.arg            = arg;
        r.typed          = typed;
        r.view.status    = st;
        r.view.found     = fnd;
        r.view.top       = top;
        r.view.not_empty = (cnt != 0);
        r.view.count     = COUNT_W'(cnt);
        directed_rows.push_back(r);
    endtask

    // Present one command word; entered and left at a falling edge. An idle
    // gap lowers start first, otherwise start stays high across words.
    task automatic send_command(input cmd_t op, input word_t arg, input int idle_pct,
                                input bit typed, input stack_view_t typed_view);
        stack_view_t predicted;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= op;
        value <= arg;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        // Taken at this edge.
        predicted = apply_command(op, arg);
        pending_views.push_back(typed ? typed_view : predicted);
        words_sent++;
        if (op == CMD_PUSH)
            last_pushed = arg;
        if (predicted.status == STAT_FULL)
            full_refusals++;
        if (predicted.status == STAT_EMPTY)
            empty_pops++;
        if (op == CMD_SEARCH)
        begin
            searches++;
            if (predicted.found)
                search_hits++;
        end
        @(negedge clk);
    endtask

    // Hold the sender off until every predicted word has come back, then
    // let the block settle.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker: done marks a word for exactly one cycle.
    always @(posedge clk)
    begin
        stack_view_t want;
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (pending_views.size() == 0)
            begin
                $display("%0t: result word with nothing expected, status %h top %h count %0d",
                         $time, status, top_value, entry_count);
                errors++;
            end
            else
            begin
                want = pending_views.pop_front();
                report_field("status", 32'(want.status), 32'(status));
                report_field("found", 32'(want.found), 32'(found));
                report_field("top_value", want.top, top_value);
                report_field("not_empty", 32'(want.not_empty), 32'(not_empty));
                report_field("entry_count", 32'(want.count), 32'(entry_count));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_views.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        stack_view_t no_view;
        cmd_t        op;
        word_t       arg;
        int          push_pct;
        int          idle_pct;
        int          roll;
        int          n_directed;

        shadow_fill = 0;
        last_pushed = '0;
        foreach (shadow_mem[i])
            shadow_mem[i] = '0;
        push_pct = 50;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. Typed rows: empty stack, extremes, error codes.
        add_row(CMD_POP,    '0,           1, STAT_EMPTY, 0, '0,           0);
        add_row(CMD_PUSH,   32'h8000_0000, 1, STAT_OK,   0, 32'h8000_0000, 1);
        add_row(CMD_PUSH,   32'h7FFF_FFFF, 1, STAT_OK,   0, 32'h7FFF_FFFF, 2);
        add_row(CMD_SEARCH, 32'h8000_0000, 1, STAT_OK,   1, 32'h7FFF_FFFF, 2);
        // pop leaving one entry: new top comes back from the RAM
        add_row(CMD_POP,    '0,           1, STAT_OK,    0, 32'h8000_0000, 1);
        add_row(CMD_POP,    '0,           1, STAT_OK,    0, '0,           0);
        // popped value is stale, must not be found
        add_row(CMD_SEARCH, 32'h8000_0000, 1, STAT_OK,   0, '0,           0);
        // fill to DEPTH; these rows go to the predictor
        add_row(CMD_PUSH,   -1,            0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   0,             0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   1,             0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'h5555_5555, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'hAAAA_AAAA, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'h0000_FFFF, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'hFFFF_0000, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'h7FFF_FFFF, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'h8000_0000, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   7,             0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   -7,            0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'h1234_5678, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'h0F0F_0F0F, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   32'hF0F0_F0F0, 0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   100,           0, STAT_OK,   0, '0, 0);
        add_row(CMD_PUSH,   -100,          1, STAT_OK,   0, -100, DEPTH);
        // push on a full stack is refused, value dropped
        add_row(CMD_PUSH,   42,            1, STAT_FULL, 0, -100, DEPTH);
        // key sits at the bottom: longest search
        add_row(CMD_SEARCH, -1,            1, STAT_OK,   1, -100, DEPTH);
        add_row(CMD_NOP,    32'hFFFF_FFFF, 1, STAT_OK,   0, -100, DEPTH);

        n_directed = directed_rows.size();
        foreach (directed_rows[i])
            send_command(directed_rows[i].op, directed_rows[i].arg, 0,
                         directed_rows[i].typed, directed_rows[i].view);
        drain_results();

        // Random phases. The receiver cannot stall, so the receiver-only
        // phase runs with no idling and the combined one idles the sender.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 55;
                3:       idle_pct = 28;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Drift the push/pop balance so the stack swings between
                // empty and full.
                if (n % 40 == 0)
                begin
                    case ($urandom_range(2))
                        0:       push_pct = 25;
                        1:       push_pct = 50;
                        default: push_pct = 80;
                    endcase
                end
                roll = $urandom_range(99);
                if (roll < 3)
                    op = CMD_NOP;
                else if (roll < 28)
                    op = CMD_SEARCH;
                else if ($urandom_range(99) < push_pct)
                    op = CMD_PUSH;
                else
                    op = CMD_POP;
                if (op == CMD_SEARCH && $urandom_range(99) < 60)
                    arg = shadow_mem[$urandom_range(DEPTH - 1)];
                else
                    arg = pick_word();
                send_command(op, arg, idle_pct, 1'b0, no_view);
            end
            drain_results();
        end

        $display("ran %0d command words (%0d directed), %0d result words checked",
                 words_sent, n_directed, results_seen);
        $display("full pushes %0d, empty pops %0d, searches %0d with %0d hits",
                 full_refusals, empty_pops, searches, search_hits);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
